>>> sv/onewire_bus_master_defines.svh
// Assertion macros used by the one-wire bus master core.
`ifndef ONEWIRE_BUS_MASTER_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define OWBM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define OWBM_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/owbm_pkg.sv
// Types, command codes and slot timing for the one-wire bus master.
package owbm_pkg;

   localparam int LINE_COUNT = 3;
   localparam int MASK_WIDTH = 3;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [8:0] RST_LOW_T  = 9'd480;
   localparam logic [8:0] RST_WAIT_T = 9'd70;
   localparam logic [8:0] RST_REC_T  = 9'd410;
   localparam logic [8:0] W1_LOW_T   = 9'd5;
   localparam logic [8:0] W1_REC_T   = 9'd55;
   localparam logic [8:0] W0_LOW_T   = 9'd65;
   localparam logic [8:0] W0_REC_T   = 9'd5;
   localparam logic [8:0] RD_LOW_T   = 9'd3;
   localparam logic [8:0] RD_WAIT_T  = 9'd10;
   localparam logic [8:0] RD_REC_T   = 9'd50;

   typedef struct packed {
      logic [MASK_WIDTH-1:0] drive_low_mask;
      logic                  busy_res;
      logic                  done_res;
      logic                  presence;
      logic [7:0]            read_data;
      logic                  rejected;
   } rsp_type;

   // Length of the low phase for the current operation and bit.
   function automatic logic [8:0] low_length(input logic [1:0] kind, input logic bit0);
      logic [8:0] len;
      case (kind)
         OP_RESET: len = RST_LOW_T;
         OP_WRITE: len = bit0 ? W1_LOW_T : W0_LOW_T;
         default:  len = RD_LOW_T;
      endcase
      return len;
   endfunction

endpackage

>>> sv/owbm_core.sv
// Bus timing state machine: advances one microsecond tick per transaction.
`include "onewire_bus_master_defines.svh"

module owbm_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [1:0]       cmd,
   input  logic [1:0]       channel,
   input  logic [7:0]       write_data,
   input  logic             line_level,
   output owbm_pkg::rsp_type step_rsp
);
   import owbm_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LOW  = 2'd1,
      PH_WAIT = 2'd2,
      PH_REC  = 2'd3
   } phase_type;

   localparam int ACTIVE_LINES = (LINE_COUNT < MASK_WIDTH) ? LINE_COUNT : MASK_WIDTH;

   phase_type  phase_ff, phase_in, phase_cur;
   logic [8:0] remaining_ff, remaining_in, remaining_cur;
   logic [2:0] bit_pos_ff, bit_pos_in, bit_pos_cur;
   logic [7:0] shift_ff, shift_in, shift_cur;
   logic [1:0] kind_ff, kind_in, kind_cur;
   logic [1:0] line_ff, line_in, line_cur;
   logic       presence_ff, presence_in;
   logic [7:0] read_result_ff, read_result_in;
   logic       rejected;
   logic       done;
   logic [MASK_WIDTH-1:0] mask;

   // Load a new operation when idle, else flag a command as rejected; the start tick is its first tick.
   always_comb begin
      phase_cur     = phase_ff;
      remaining_cur = remaining_ff;
      bit_pos_cur   = bit_pos_ff;
      shift_cur     = shift_ff;
      kind_cur      = kind_ff;
      line_cur      = line_ff;
      rejected      = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (cmd != OP_TICK) begin
            kind_cur      = cmd;
            line_cur      = channel;
            bit_pos_cur   = 3'd0;
            shift_cur     = (cmd == OP_WRITE) ? write_data : 8'd0;
            phase_cur     = PH_LOW;
            remaining_cur = low_length(cmd, shift_cur[0]);
         end
      end else if (cmd != OP_TICK) begin
         rejected = 1'b1;
      end
   end

   always_comb begin
      phase_in       = phase_cur;
      remaining_in   = remaining_cur;
      bit_pos_in     = bit_pos_cur;
      shift_in       = shift_cur;
      kind_in        = kind_cur;
      line_in        = line_cur;
      presence_in    = presence_ff;
      read_result_in = read_result_ff;
      done           = 1'b0;
      mask           = '0;
      if (phase_cur != PH_IDLE) begin
         if (phase_cur == PH_LOW && int'(line_cur) < ACTIVE_LINES) begin
            mask = MASK_WIDTH'(1) << line_cur;
         end
         if (remaining_cur > 9'd1) begin
            remaining_in = remaining_cur - 9'd1;
         end else begin
            case (phase_cur)
               PH_LOW: begin
                  if (kind_cur == OP_WRITE) begin
                     phase_in     = PH_REC;
                     remaining_in = shift_cur[0] ? W1_REC_T : W0_REC_T;
                  end else begin
                     phase_in     = PH_WAIT;
                     remaining_in = (kind_cur == OP_RESET) ? RST_WAIT_T : RD_WAIT_T;
                  end
               end
               PH_WAIT: begin
                  // Sample the line on the last released tick
                  if (kind_cur == OP_RESET) begin
                     presence_in = ~line_level;
                  end else begin
                     shift_in = {line_level, shift_cur[7:1]};
                  end
                  phase_in     = PH_REC;
                  remaining_in = (kind_cur == OP_RESET) ? RST_REC_T : RD_REC_T;
               end
               default: begin
                  if (kind_cur != OP_RESET && bit_pos_cur != 3'd7) begin
                     // Advance to the next bit slot
                     shift_in     = (kind_cur == OP_WRITE) ? {1'b0, shift_cur[7:1]} : shift_cur;
                     bit_pos_in   = bit_pos_cur + 3'd1;
                     phase_in     = PH_LOW;
                     remaining_in = low_length(kind_cur,
                                               (kind_cur == OP_WRITE) ? shift_cur[1]
                                                                      : shift_cur[0]);
                  end else begin
                     if (kind_cur == OP_WRITE) begin
                        shift_in = {1'b0, shift_cur[7:1]};
                     end
                     if (kind_cur == OP_READ) begin
                        read_result_in = shift_cur;
                     end
                     phase_in     = PH_IDLE;
                     remaining_in = 9'd0;
                     bit_pos_in   = 3'd0;
                     done         = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         remaining_ff   <= 9'd0;
         bit_pos_ff     <= 3'd0;
         shift_ff       <= 8'd0;
         kind_ff        <= OP_TICK;
         line_ff        <= 2'd0;
         presence_ff    <= 1'b0;
         read_result_ff <= 8'd0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         remaining_ff   <= remaining_in;
         bit_pos_ff     <= bit_pos_in;
         shift_ff       <= shift_in;
         kind_ff        <= kind_in;
         line_ff        <= line_in;
         presence_ff    <= presence_in;
         read_result_ff <= read_result_in;
      end
   end

   assign step_rsp.drive_low_mask = mask;
   assign step_rsp.busy_res       = (phase_in != PH_IDLE);
   assign step_rsp.done_res       = done;
   assign step_rsp.presence       = presence_in;
   assign step_rsp.read_data      = read_result_in;
   assign step_rsp.rejected       = rejected;

   `OWBM_ASSERT(a_busy_has_count, (phase_ff == PH_IDLE) || (remaining_ff != 9'd0), "busy with zero count")
   `OWBM_ASSERT(a_bits_only_in_byte_ops, (bit_pos_ff == 3'd0) || ((kind_ff != OP_RESET) && (phase_ff != PH_IDLE)), "bit position outside a byte operation")
   `OWBM_ASSERT_NEXT(a_done_goes_idle, step_en && done, (phase_ff == PH_IDLE) && (bit_pos_ff == 3'd0), "finished operation did not return to idle")

endmodule

>>> sv/owbm_out_reg.sv
// Result register: holds one transaction until the consumer takes it.
module owbm_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  owbm_pkg::rsp_type load_rsp,
   output logic              in_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output owbm_pkg::rsp_type rsp_data
);
   import owbm_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign in_ready = ~valid_ff | rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_rsp;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> sv/onewire_bus_master.sv
// A result is registered and valid in the cycle after its tick transaction is accepted.
// One tick transaction is accepted per clock while the result register is free; the state update is a single pass.
// The result register frees req_ready whenever the result is taken or absent.
// Reset (synchronous, active high) returns to idle with presence and read byte cleared.
// Top level of the one-wire bus master.
module onewire_bus_master (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_cmd,
   input  logic [1:0]                      req_channel,
   input  logic [7:0]                      req_write_data,
   input  logic                            req_line_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [owbm_pkg::MASK_WIDTH-1:0] rsp_drive_low_mask,
   output logic                            rsp_busy_res,
   output logic                            rsp_done_res,
   output logic                            rsp_presence,
   output logic [7:0]                      rsp_read_data,
   output logic                            rsp_rejected
);
   import owbm_pkg::*;

   logic    req_accept;
   rsp_type step_rsp;
   rsp_type rsp_data;

   assign req_accept = req_valid & req_ready;

   owbm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (req_accept),
      .cmd        (req_cmd),
      .channel    (req_channel),
      .write_data (req_write_data),
      .line_level (req_line_level),
      .step_rsp   (step_rsp)
   );

   owbm_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .load_rsp  (step_rsp),
      .in_ready  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_drive_low_mask = rsp_data.drive_low_mask;
   assign rsp_busy_res       = rsp_data.busy_res;
   assign rsp_done_res       = rsp_data.done_res;
   assign rsp_presence       = rsp_data.presence;
   assign rsp_read_data      = rsp_data.read_data;
   assign rsp_rejected       = rsp_data.rejected;

endmodule
